>>> rtl/bdeq_pkg.sv
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared types and codes of the byte double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int FILL_W = 5;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_REAR  = 3'd5;

    // Status codes carried in the result.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_HOLD  = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // an item is taken at this edge
        logic capture;  // the result of the taken item is loaded
    } cmd_t;

endpackage

>>> rtl/bdeq_if.sv
// ----------------------------------------------------------------------------
// bdeq_if
// Request and response channels of the byte double-ended queue.
// ----------------------------------------------------------------------------
interface bdeq_in_if;
    import bdeq_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] push_byte;

    modport source (output valid, output mode, output push_byte, input ready);
    modport sink   (input valid, input mode, input push_byte, output ready);
endinterface

interface bdeq_out_if;
    import bdeq_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_count;

    modport source (output valid, output out_byte, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input fill_count,
                    output ready);
endinterface

>>> rtl/bdeq_ram.sv
// ----------------------------------------------------------------------------
// bdeq_ram
// Generic single-write, single-read memory with a registered read.
// ----------------------------------------------------------------------------
module bdeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/bdeq_ctrl.sv
// ----------------------------------------------------------------------------
// bdeq_ctrl
// Handshake controller: takes an item, waits for the read, holds the result.
// ----------------------------------------------------------------------------
module bdeq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bdeq_pkg::cmd_t cmd
);
    import bdeq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // A new item may enter while the held result leaves in the same cycle.
    assign req_ready   = (state_reg == S_IDLE) || ((state_reg == S_HOLD) && rsp_ready);
    assign rsp_valid   = (state_reg == S_HOLD);
    assign cmd.accept  = req_valid && req_ready;
    assign cmd.capture = (state_reg == S_FETCH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (rsp_ready)
                begin
                    state_next = req_valid ? S_FETCH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> rtl/bdeq_dp.sv
// ----------------------------------------------------------------------------
// bdeq_dp
// Queue datapath: ring indexes, entry count, entry memory and result register.
// ----------------------------------------------------------------------------
module bdeq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bdeq_pkg::cmd_t                cmd,
    input  logic [bdeq_pkg::MODE_W-1:0]   mode,
    input  logic [bdeq_pkg::BYTE_W-1:0]   push_byte,
    output logic [bdeq_pkg::BYTE_W-1:0]   out_byte,
    output logic [bdeq_pkg::STAT_W-1:0]   status,
    output logic [bdeq_pkg::FILL_W-1:0]   fill_count
);
    import bdeq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] rear_reg,  rear_next;
    logic [CW-1:0] count_reg, count_next;

    logic [AW-1:0] front_inc, front_dec, rear_inc, rear_dec;
    logic          is_full, is_empty;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] rdata;
    logic              rd_hit;
    logic [STAT_W-1:0] stat_now;

    logic              rd_pend_reg;
    logic [STAT_W-1:0] stat_pend_reg;
    logic [FILL_W-1:0] fill_pend_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [STAT_W-1:0] status_reg;
    logic [FILL_W-1:0] fill_reg;

    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + AW'(1);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
    assign rear_inc  = (rear_reg == LAST_IDX) ? '0 : rear_reg + AW'(1);
    assign rear_dec  = (rear_reg == '0) ? LAST_IDX : rear_reg - AW'(1);
    assign is_full   = (count_reg == FULL_CNT);
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        we         = 1'b0;
        waddr      = rear_reg;
        raddr      = front_reg;
        rd_hit     = 1'b0;
        stat_now   = STAT_OK;
        if (cmd.accept)
        begin
            unique case (mode)
                MODE_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        stat_now = STAT_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        waddr      = front_dec;
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        stat_now = STAT_FULL;
                    end
                    else
                    begin
                        rear_next  = rear_inc;
                        waddr      = rear_reg;
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_POP_FRONT, MODE_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        stat_now = STAT_EMPTY;
                    end
                    else
                    begin
                        raddr  = front_reg;
                        rd_hit = 1'b1;
                        if (mode == MODE_POP_FRONT)
                        begin
                            front_next = front_inc;
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                MODE_POP_REAR, MODE_PEEK_REAR:
                begin
                    if (is_empty)
                    begin
                        stat_now = STAT_EMPTY;
                    end
                    else
                    begin
                        raddr  = rear_dec;
                        rd_hit = 1'b1;
                        if (mode == MODE_POP_REAR)
                        begin
                            rear_next  = rear_dec;
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                default:
                begin
                    // Unused codes leave the queue untouched and report ok.
                    stat_now = STAT_OK;
                end
            endcase
        end
    end

    bdeq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (push_byte),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_pend_reg   <= rd_hit;
            stat_pend_reg <= stat_now;
            fill_pend_reg <= FILL_W'(count_next);
        end
        if (cmd.capture)
        begin
            out_byte_reg <= rd_pend_reg ? rdata : '0;
            status_reg   <= stat_pend_reg;
            fill_reg     <= fill_pend_reg;
        end
    end

    assign out_byte   = out_byte_reg;
    assign status     = status_reg;
    assign fill_count = fill_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_ring_span: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> front_reg == rear_reg)
        else $error("indexes disagree with empty or full count");
`endif
endmodule

>>> rtl/byte_double_ended_queue.sv
// A result is offered once the entry memory read has been loaded into the result register.
// The block takes no new item until the held result is taken, set by the registered read of the entry memory.
// A new item is taken in the same cycle the held result is taken.
// Reset (rst_n low, asynchronous) empties the queue; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
// byte_double_ended_queue
// Byte deque in a ring buffer of DEPTH entries with push, pop and peek at
// both ends. Every item returns one result with the byte, a status code and
// the number of stored entries after the operation.
// ----------------------------------------------------------------------------
module byte_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    bdeq_in_if.sink   req,
    bdeq_out_if.source rsp
);
    import bdeq_pkg::*;

    cmd_t cmd;

    // The controller owns the handshake and sequencing. It tells the
    // datapath when an item is taken and when its read data has arrived.
    bdeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // The datapath decodes the operation, updates the front and rear indexes
    // and the count at the accept edge, writes or reads the entry memory,
    // and loads the result register in the following cycle.
    bdeq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .mode       (req.mode),
        .push_byte  (req.push_byte),
        .out_byte   (rsp.out_byte),
        .status     (rsp.status),
        .fill_count (rsp.fill_count)
    );

`ifndef SYNTHESIS
    // A taken item never shows its result in the very next cycle.
    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !rsp.valid)
        else $error("result offered before the read completed");

    // An empty report always comes with a zero byte and an empty queue.
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_EMPTY) |-> (rsp.out_byte == '0 && rsp.fill_count == '0))
        else $error("empty status with data or entries");

    // A dropped push reports the queue at full depth.
    a_full_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_FULL)
            |-> (rsp.out_byte == '0 && rsp.fill_count == FILL_W'(DEPTH)))
        else $error("full status with wrong count or data");
`endif
endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte double-ended queue. A shadow deque follows
// every accepted item and predicts its result, which is then compared field by
// field with what the block returns. Directed items cover the empty and full
// corners, then biased random traffic fills and drains the queue repeatedly.
// ----------------------------------------------------------------------------

import bdeq_pkg::*;

// One result of the deque as it appears on the response channel.
typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_count;
} deque_result_t;

class deque_shadow;
    int unsigned      capacity;
    logic [BYTE_W-1:0] slots[];
    int unsigned      front_pos;
    int unsigned      rear_pos;
    int unsigned      entries;
    deque_result_t    expected_results[$];
    int unsigned      mismatch_count;

    function new(int unsigned depth_entries);
        capacity       = depth_entries;
        slots          = new[depth_entries];
        front_pos      = 0;
        rear_pos       = 0;
        entries        = 0;
        mismatch_count = 0;
    endfunction

    // Applies one accepted operation to the shadow deque and queues its result.
    function void note_item(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data);
        deque_result_t res;
        res.out_byte = '0;
        res.status   = STAT_OK;
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR:
                if (entries >= capacity)
                    res.status = STAT_FULL;
                else
                begin
                    if (mode == MODE_PUSH_FRONT)
                    begin
                        front_pos        = (front_pos + capacity - 1) % capacity;
                        slots[front_pos] = data;
                    end
                    else
                    begin
                        slots[rear_pos] = data;
                        rear_pos        = (rear_pos + 1) % capacity;
                    end
                    entries++;
                end
            MODE_POP_FRONT, MODE_PEEK_FRONT:
                if (entries == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.out_byte = slots[front_pos];
                    if (mode == MODE_POP_FRONT)
                    begin
                        front_pos = (front_pos + 1) % capacity;
                        entries--;
                    end
                end
            MODE_POP_REAR, MODE_PEEK_REAR:
                if (entries == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.out_byte = slots[(rear_pos + capacity - 1) % capacity];
                    if (mode == MODE_POP_REAR)
                    begin
                        rear_pos = (rear_pos + capacity - 1) % capacity;
                        entries--;
                    end
                end
            default:
                ;
        endcase
        res.fill_count = entries[FILL_W-1:0];
        expected_results.push_back(res);
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compares one returned result with the oldest prediction.
    task check_result(deque_result_t got);
        deque_result_t want;
        if (expected_results.size() == 0)
        begin
            report($sformatf("result byte=%02h status=%0d fill=%0d with none pending",
                             got.out_byte, got.status, got.fill_count));
            return;
        end
        want = expected_results.pop_front();
        if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, predicted %02h", got.out_byte, want.out_byte));
        if (got.status !== want.status)
            report($sformatf("status %0d, predicted %0d", got.status, want.status));
        if (got.fill_count !== want.fill_count)
            report($sformatf("fill_count %0d, predicted %0d", got.fill_count, want.fill_count));
    endtask
endclass

module testbench;

    localparam int QUEUE_DEPTH     = 16;
    localparam int RANDOM_ITEMS    = 850;
    // From this random item on, neither side idles any more.
    localparam int QUIET_FROM      = 700;
    // Random item at which the receiver starts its long hold-off.
    localparam int PRESSURE_AT     = 350;
    localparam int PRESSURE_CYCLES = 80;
    // Wait after the last predicted result; this leaves ample room for strays.
    localparam int DRAIN_CYCLES    = 10;
    // Worst case per item is the longest random send gap, the longest random
    // receive stall and the pass through the block; this limit is several times that.
    localparam int CYCLE_LIMIT     = 200000;

    // Mode values that name no operation; the block must answer them unchanged.
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bdeq_in_if  req_ch ();
    bdeq_out_if rsp_ch ();

    byte_double_ended_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deque_shadow shadow = new(QUEUE_DEPTH);

    bit          quiet_phase  = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_active  = 1'b0;
    int unsigned cycle_count  = 0;

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offers one item starting at a falling edge and returns at the falling edge
    // after it was taken. Before the item the sender may idle for a random burst,
    // except during the receiver hold-off (so the block fills and stalls) and in
    // the quiet tail of the run.
    task offer_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data);
        if (!quiet_phase && !hold_active && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.mode      = mode;
        req_ch.push_byte = data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        shadow.note_item(mode, data);
        @(negedge clk);
    endtask

    // Stimulus: reset, the directed corners, then biased random traffic.
    initial
    begin
        int unsigned       push_pct;
        int unsigned       roll;
        logic [MODE_W-1:0] mode;

        push_pct         = 50;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_PUSH_FRONT;
        req_ch.push_byte = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every removal and peek on the empty queue, then both unused modes.
        offer_item(MODE_POP_FRONT, 8'h00);
        offer_item(MODE_POP_REAR, 8'hFF);
        offer_item(MODE_PEEK_FRONT, 8'h00);
        offer_item(MODE_PEEK_REAR, 8'hFF);
        offer_item(MODE_UNUSED_LO, 8'hFF);
        offer_item(MODE_UNUSED_HI, 8'h00);

        // Extreme bytes at both ends, seen through the peeks.
        offer_item(MODE_PUSH_FRONT, 8'h00);
        offer_item(MODE_PUSH_REAR, 8'hFF);
        offer_item(MODE_PEEK_FRONT, 8'h00);
        offer_item(MODE_PEEK_REAR, 8'h00);

        // Fill to capacity from both ends, wrapping the front index below zero,
        // then try a push at each end of the full queue.
        for (int k = 0; k < QUEUE_DEPTH - 2; k++)
            offer_item(k[0] ? MODE_PUSH_REAR : MODE_PUSH_FRONT, 8'(k * 37 + 5));
        offer_item(MODE_PUSH_FRONT, 8'hA5);
        offer_item(MODE_PUSH_REAR, 8'h5A);

        // Random part. Every 32 items the push share is redrawn so the queue
        // swings between full and empty instead of hovering at one level.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 32 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 75;
                    1:       push_pct = 30;
                    default: push_pct = 52;
                endcase
            end
            if (n == QUIET_FROM)
                quiet_phase = 1'b1;
            if (n == PRESSURE_AT)
                hold_request = 1'b1;

            roll = $urandom_range(0, 99);
            if (roll < 4)
                mode = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
            else if (roll < push_pct)
                mode = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
            else
            begin
                // Removals outnumber peeks so the queue actually drains.
                case ($urandom_range(0, 5))
                    0, 1:    mode = MODE_POP_FRONT;
                    2, 3:    mode = MODE_POP_REAR;
                    4:       mode = MODE_PEEK_FRONT;
                    default: mode = MODE_PEEK_REAR;
                endcase
            end
            offer_item(mode, 8'($urandom_range(0, 255)));
        end
        req_ch.valid = 1'b0;

        // Wait for every predicted result, then a little longer to catch strays.
        while (shadow.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.mismatch_count == 0 && shadow.expected_results.size() == 0)
            $display("[byte_double_ended_queue] OK");
        else
            $display("[byte_double_ended_queue] ERROR");
        $finish;
    end

    // Receiver: ready changes on falling edges. It stalls in random bursts, and
    // once holds off for a long stretch counted here so that the block's held
    // result blocks the input while the sender keeps offering items.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                rsp_ch.ready = 1'b0;
                for (int c = 0; c < PRESSURE_CYCLES; c++)
                    @(negedge clk);
                hold_active  = 1'b0;
                rsp_ch.ready = 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                rsp_ch.ready = 1'b1;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    // Every result taken at a rising edge is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.check_result({rsp_ch.out_byte, rsp_ch.status, rsp_ch.fill_count});
    end

    // Watchdog against a hung handshake.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[byte_double_ended_queue] ERROR");
        $finish;
    end

endmodule
